// File: rtl/image_fit_placement_unit_defines.svh
// Assertion macros for the checker file of the image fit placement unit.
`ifndef IMAGE_FIT_PLACEMENT_UNIT_DEFINES_SVH
`define IMAGE_FIT_PLACEMENT_UNIT_DEFINES_SVH

// Checked at every edge outside reset.
`define IFP_ASSERT_RUN(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);

// Checked at every edge, reset included.
`define IFP_ASSERT_ALL(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) expr) else $error(msg);

`endif

// File: rtl/ifp_pkg.sv
// Package with the request and result types and the fit mode codes.
package ifp_pkg;

    localparam logic [1:0] MODE_COVER   = 2'd0;
    localparam logic [1:0] MODE_CONTAIN = 2'd1;
    localparam logic [1:0] MODE_SPAN    = 2'd2;
    localparam logic [1:0] MODE_CENTER  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] image_w;
        logic [15:0] image_h;
        logic [15:0] target_w;
        logic [15:0] target_h;
        logic [15:0] canvas_w;
        logic [15:0] canvas_h;
        logic [15:0] slice_x;
        logic [15:0] slice_y;
        logic [15:0] slice_w;
        logic [15:0] slice_h;
    } t_req;

    typedef struct packed {
        logic [15:0] crop_x;
        logic [15:0] crop_y;
        logic [15:0] crop_w;
        logic [15:0] crop_h;
        logic [15:0] place_x;
        logic [15:0] place_y;
        logic [15:0] place_w;
        logic [15:0] place_h;
        logic        bad_size;
    } t_rsp;

endpackage

// File: rtl/ifp_div_cell.sv
// One restoring division step for several lanes, with a registered sideband.
module ifp_div_cell #(
    parameter int D      = 16,
    parameter int QW     = 16,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][D-1:0]       i_div,
    input  logic [LANES-1:0][D-1:0]       i_rem,
    input  logic [LANES-1:0][QW-1:0]      i_dq,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][D-1:0]       o_div,
    output logic [LANES-1:0][D-1:0]       o_rem,
    output logic [LANES-1:0][QW-1:0]      o_dq,
    output logic [SIDE_W-1:0]             o_side
);

    logic                     r_valid;
    logic [LANES-1:0][D-1:0]  r_div;
    logic [LANES-1:0][D-1:0]  r_rem;
    logic [LANES-1:0][QW-1:0] r_dq;
    logic [SIDE_W-1:0]        r_side;
    logic [LANES-1:0][D-1:0]  n_rem;
    logic [LANES-1:0][QW-1:0] n_dq;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [D:0] w_trial;
        logic       w_ge;
        assign w_trial  = {i_rem[l], i_dq[l][QW-1]};
        assign w_ge     = (w_trial >= {1'b0, i_div[l]});
        assign n_rem[l] = w_ge ? D'(w_trial - {1'b0, i_div[l]}) : w_trial[D-1:0];
        assign n_dq[l]  = {i_dq[l][QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_rem  <= n_rem;
            r_dq   <= n_dq;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_side  = r_side;

endmodule

// File: rtl/ifp_div_chain.sv
// Row of division cells that yields one quotient bit per cell.
module ifp_div_chain #(
    parameter int D      = 16,
    parameter int QW     = 16,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [LANES-1:0][D-1:0]  i_div,
    input  logic [LANES-1:0][D-1:0]  i_rem,
    input  logic [LANES-1:0][QW-1:0] i_dq,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [LANES-1:0][QW-1:0] o_quo,
    output logic [SIDE_W-1:0]        o_side
);

    logic                     w_valid [QW+1];
    logic [LANES-1:0][D-1:0]  w_div   [QW+1];
    logic [LANES-1:0][D-1:0]  w_rem   [QW+1];
    logic [LANES-1:0][QW-1:0] w_dq    [QW+1];
    logic [SIDE_W-1:0]        w_side  [QW+1];

    assign w_valid[0] = i_valid;
    assign w_div[0]   = i_div;
    assign w_rem[0]   = i_rem;
    assign w_dq[0]    = i_dq;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        ifp_div_cell #(
            .D(D), .QW(QW), .LANES(LANES), .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_div   (w_div[k]),
            .i_rem   (w_rem[k]),
            .i_dq    (w_dq[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_div   (w_div[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_dq    (w_dq[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    assign o_valid = w_valid[QW];
    assign o_quo   = w_dq[QW];
    assign o_side  = w_side[QW];

endmodule

// File: rtl/image_fit_placement_unit.sv
// Throughput: one transaction per cycle unless the output is stalled.
// The whole pipeline moves in lockstep.
// The two rows of divider cells, DIM_BITS and 2*DIM_BITS long, make up most of its depth.
// The pipeline freezes only while a result waits in the output register and is stalled.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module image_fit_placement_unit #(
    parameter int DIM_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ifp_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output ifp_pkg::t_rsp o_rsp
);

    localparam int D = DIM_BITS;
    localparam int P = 2 * DIM_BITS;

    typedef struct packed {
        logic [1:0]   mode;
        logic         degen;
        logic [D-1:0] iw, ih, tw, th, lw, lh, sx, sy, sw, sh;
    } t_job;

    typedef struct packed {
        t_job         job;
        logic         wider;
        logic [D-1:0] ow, oh;
    } t_d1side;

    typedef struct packed {
        logic [D-1:0] x, y, w, h;
    } t_box;

    typedef struct packed {
        logic [1:0]   mode;
        logic         degen;
        logic         bad;
        t_box         src;
        t_box         dst;
        logic [D-1:0] lw, lh, sx, sy, sw, sh;
    } t_pre;

    typedef struct packed {
        logic [D:0] pos;
        logic [D:0] len;
        logic       bad;
    } t_line;

    // The whole pipeline advances unless a finished result is held by the consumer.
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Stage A: request fields cut to DIM_BITS, span degeneracy decoded.
    t_job n_job;
    t_job r_a_job;
    logic r_a_valid;

    always_comb begin
        n_job.mode  = i_req.req_type;
        n_job.iw    = D'(i_req.image_w);
        n_job.ih    = D'(i_req.image_h);
        n_job.tw    = D'(i_req.target_w);
        n_job.th    = D'(i_req.target_h);
        n_job.lw    = D'(i_req.canvas_w);
        n_job.lh    = D'(i_req.canvas_h);
        n_job.sx    = D'(i_req.slice_x);
        n_job.sy    = D'(i_req.slice_y);
        n_job.sw    = D'(i_req.slice_w);
        n_job.sh    = D'(i_req.slice_h);
        n_job.degen = (n_job.lw == '0) || (n_job.lh == '0) ||
                      (n_job.sw == '0) || (n_job.sh == '0);
    end

    // Stage B: the two cross products that decide which axis is cropped.
    // A span request that is not degenerate covers the layout, else the target.
    logic [D-1:0] w_ow, w_oh;
    logic         r_b_valid;
    t_job         r_b_job;
    logic [D-1:0] r_b_ow, r_b_oh;
    logic [P-1:0] r_b_p1, r_b_p2;

    assign w_ow = (r_a_job.mode == ifp_pkg::MODE_SPAN && !r_a_job.degen) ? r_a_job.lw
                                                                          : r_a_job.tw;
    assign w_oh = (r_a_job.mode == ifp_pkg::MODE_SPAN && !r_a_job.degen) ? r_a_job.lh
                                                                          : r_a_job.th;

    // First divider: cover crop length, or contain letterbox length.
    t_d1side      w_d1_in;
    logic [P-1:0] w_d1_dividend;
    logic [D-1:0] w_d1_divisor;

    always_comb begin
        w_d1_in.job   = r_b_job;
        w_d1_in.ow    = r_b_ow;
        w_d1_in.oh    = r_b_oh;
        w_d1_in.wider = (r_b_p1 > r_b_p2);
        w_d1_dividend = w_d1_in.wider ? r_b_p2 : r_b_p1;
        if (r_b_job.mode == ifp_pkg::MODE_CONTAIN) begin
            w_d1_divisor = w_d1_in.wider ? r_b_job.iw : r_b_job.ih;
        end else begin
            w_d1_divisor = w_d1_in.wider ? r_b_oh : r_b_ow;
        end
    end

    logic         w_d1_valid;
    logic [D-1:0] w_d1_quo;
    t_d1side      w_d1_out;

    // The quotient always fits DIM_BITS where it is used, so the upper dividend
    // half starts as the partial remainder and only DIM_BITS steps are needed.
    ifp_div_chain #(
        .D(D), .QW(D), .LANES(1), .SIDE_W($bits(t_d1side))
    ) u_div_crop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_valid),
        .i_div   (w_d1_divisor),
        .i_rem   (w_d1_dividend[P-1:D]),
        .i_dq    (w_d1_dividend[D-1:0]),
        .i_side  (w_d1_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_out)
    );

    // Stage G: per-mode rectangles from the first quotient.
    t_pre n_pre;

    always_comb begin
        t_job         j;
        logic [D-1:0] cut;
        logic [D-1:0] dw, dh;
        t_box         cov;
        logic         cov_bad;
        logic [D-1:0] vw, vh;
        j = w_d1_out.job;
        if (w_d1_out.wider) begin
            cut     = (w_d1_quo > j.iw) ? j.iw : w_d1_quo;
            cov.x   = (j.iw - cut) >> 1;
            cov.y   = '0;
            cov.w   = cut;
            cov.h   = j.ih;
            cov_bad = (w_d1_out.oh == '0);
        end else begin
            cut     = (w_d1_quo > j.ih) ? j.ih : w_d1_quo;
            cov.x   = '0;
            cov.y   = (j.ih - cut) >> 1;
            cov.w   = j.iw;
            cov.h   = cut;
            cov_bad = (w_d1_out.ow == '0);
        end
        vw = (j.iw < j.tw) ? j.iw : j.tw;
        vh = (j.ih < j.th) ? j.ih : j.th;
        dw = w_d1_out.wider ? j.tw : w_d1_quo;
        dh = w_d1_out.wider ? w_d1_quo : j.th;
        if (dw == '0) dw = D'(1);
        if (dh == '0) dh = D'(1);

        n_pre.mode  = j.mode;
        n_pre.degen = j.degen;
        n_pre.lw    = j.lw;
        n_pre.lh    = j.lh;
        n_pre.sx    = j.sx;
        n_pre.sy    = j.sy;
        n_pre.sw    = j.sw;
        n_pre.sh    = j.sh;
        n_pre.src   = cov;
        n_pre.dst   = '{x: '0, y: '0, w: j.tw, h: j.th};
        n_pre.bad   = cov_bad;
        case (j.mode)
            ifp_pkg::MODE_CONTAIN: begin
                n_pre.src = '{x: '0, y: '0, w: j.iw, h: j.ih};
                n_pre.dst = '{x: (j.tw - dw) >> 1, y: (j.th - dh) >> 1, w: dw, h: dh};
                n_pre.bad = (w_d1_out.wider ? (j.iw == '0) : (j.ih == '0)) ||
                            (dw > j.tw) || (dh > j.th);
            end
            ifp_pkg::MODE_CENTER: begin
                n_pre.src = '{x: (j.iw - vw) >> 1, y: (j.ih - vh) >> 1, w: vw, h: vh};
                n_pre.dst = '{x: (j.tw - vw) >> 1, y: (j.th - vh) >> 1, w: vw, h: vh};
                n_pre.bad = 1'b0;
            end
            default: begin
            end
        endcase
    end

    logic r_g_valid;
    t_pre r_g_pre;

    // Stage H: slice products against the covered rectangle for the span mode.
    logic                 r_h_valid;
    t_pre                 r_h_pre;
    logic [3:0][P-1:0]    r_h_prod;
    logic [3:0][D-1:0]    w_d2_div;
    logic [3:0][D-1:0]    w_d2_rem;

    assign w_d2_div = {r_h_pre.lh, r_h_pre.lh, r_h_pre.lw, r_h_pre.lw};
    assign w_d2_rem = '0;

    // Second divider: four lanes, full-width quotients (slice start and length per axis).
    logic              w_d2_valid;
    logic [3:0][P-1:0] w_d2_quo;
    t_pre              w_d2_pre;

    ifp_div_chain #(
        .D(D), .QW(P), .LANES(4), .SIDE_W($bits(t_pre))
    ) u_div_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_valid),
        .i_div   (w_d2_div),
        .i_rem   (w_d2_rem),
        .i_dq    (r_h_prod),
        .i_side  (r_h_pre),
        .o_valid (w_d2_valid),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_pre)
    );

    // Clamp one axis of a slice to the covered rectangle.
    function automatic t_line span_line(input logic [D-1:0] cpos, input logic [D-1:0] clen,
                                        input logic [P-1:0] q, input logic [P-1:0] len);
        logic [D:0]   limit;
        logic [D:0]   pos;
        logic [D:0]   remain;
        logic [P-1:0] len1;
        t_line        r;
        limit = {1'b0, cpos} + {1'b0, clen};
        if (q >= P'(clen)) begin
            pos = limit - 1'b1;
        end else begin
            pos = {1'b0, cpos} + (D+1)'(q);
        end
        remain = limit - pos;
        len1   = (len == '0) ? P'(1) : len;
        r.len  = (len1 > P'(remain)) ? remain : (D+1)'(len1);
        r.pos  = pos;
        r.bad  = (limit == '0);
        return r;
    endfunction

    // Final stage: span override, bad request zeroing, output register.
    ifp_pkg::t_rsp n_rsp;

    always_comb begin
        t_line lx, ly;
        t_box  src;
        logic  bad;
        lx  = span_line(w_d2_pre.src.x, w_d2_pre.src.w, w_d2_quo[0], w_d2_quo[1]);
        ly  = span_line(w_d2_pre.src.y, w_d2_pre.src.h, w_d2_quo[2], w_d2_quo[3]);
        src = w_d2_pre.src;
        bad = w_d2_pre.bad;
        if (w_d2_pre.mode == ifp_pkg::MODE_SPAN && !w_d2_pre.degen) begin
            src.x = D'(lx.pos);
            src.w = D'(lx.len);
            src.y = D'(ly.pos);
            src.h = D'(ly.len);
            bad   = bad || lx.bad || ly.bad;
        end
        if (bad) begin
            n_rsp          = '0;
            n_rsp.bad_size = 1'b1;
        end else begin
            n_rsp.crop_x   = 16'(src.x);
            n_rsp.crop_y   = 16'(src.y);
            n_rsp.crop_w   = 16'(src.w);
            n_rsp.crop_h   = 16'(src.h);
            n_rsp.place_x  = 16'(w_d2_pre.dst.x);
            n_rsp.place_y  = 16'(w_d2_pre.dst.y);
            n_rsp.place_w  = 16'(w_d2_pre.dst.w);
            n_rsp.place_h  = 16'(w_d2_pre.dst.h);
            n_rsp.bad_size = 1'b0;
        end
    end

    logic          r_out_valid;
    ifp_pkg::t_rsp r_out_rsp;

    // Valid bits of the hand-built stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_g_valid   <= 1'b0;
            r_h_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_g_valid   <= w_d1_valid;
            r_h_valid   <= r_g_valid;
            r_out_valid <= w_d2_valid;
        end
    end

    // Payload registers; each multiplication lands in a register of its own.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_job     <= n_job;
            r_b_job     <= r_a_job;
            r_b_ow      <= w_ow;
            r_b_oh      <= w_oh;
            r_b_p1      <= P'(r_a_job.iw) * P'(w_oh);
            r_b_p2      <= P'(w_ow) * P'(r_a_job.ih);
            r_g_pre     <= n_pre;
            r_h_pre     <= r_g_pre;
            r_h_prod[0] <= P'(r_g_pre.sx) * P'(r_g_pre.src.w);
            r_h_prod[1] <= P'(r_g_pre.sw) * P'(r_g_pre.src.w);
            r_h_prod[2] <= P'(r_g_pre.sy) * P'(r_g_pre.src.h);
            r_h_prod[3] <= P'(r_g_pre.sh) * P'(r_g_pre.src.h);
            r_out_rsp   <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

endmodule

// File: rtl/ifp_checker.sv
// Port-level checker for the image fit placement unit, with its bind statement.
`include "image_fit_placement_unit_defines.svh"

module ifp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input ifp_pkg::t_rsp o_rsp
);

    // The input side is held back exactly when a finished result is held.
    `IFP_ASSERT_RUN(a_stall_follows_output, o_stall == (o_valid && i_stall), "input stall mismatch")

    // A bad request returns all rectangle fields as zero.
    `IFP_ASSERT_RUN(a_bad_is_zero, (o_valid && o_rsp.bad_size) |-> (o_rsp.crop_x == 16'd0 && o_rsp.crop_y == 16'd0 && o_rsp.crop_w == 16'd0 && o_rsp.crop_h == 16'd0 && o_rsp.place_x == 16'd0 && o_rsp.place_y == 16'd0 && o_rsp.place_w == 16'd0 && o_rsp.place_h == 16'd0), "bad result not zeroed")

    // A stalled result transaction stays in place.
    `IFP_ASSERT_RUN(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)), "stalled result changed")

    // Reset empties the output register.
    `IFP_ASSERT_ALL(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind image_fit_placement_unit ifp_checker u_ifp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// File: test/placement_checker.sv
// Checker that predicts image fit placement results and compares them with the block.
`timescale 1ns / 100ps

module placement_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_in_stall,
    input  ifp_pkg::t_req i_req,
    input  logic          i_out_valid,
    input  logic          i_stall,
    input  ifp_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);

    ifp_pkg::t_rsp placement_queue[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = placement_queue.size();

    typedef struct {
        logic [63:0] x, y, w, h;
    } t_box;

    function automatic bit cover_fit(logic [63:0] sw, sh, ow, oh, output t_box r);
        logic [63:0] c;
        r = '{0, 0, 0, 0};
        if (sw * oh > ow * sh) begin
            if (oh == 0) return 0;
            c = sh * ow / oh;
            if (c > sw) c = sw;
            r.w = c; r.h = sh; r.x = (sw - c) / 2; r.y = 0;
        end else begin
            if (ow == 0) return 0;
            c = sw * oh / ow;
            if (c > sh) c = sh;
            r.w = sw; r.h = c; r.x = 0; r.y = (sh - c) / 2;
        end
        return 1;
    endfunction

    function automatic bit slice_axis(logic [63:0] cpos, clen, spos, slen, llen,
                                      output logic [63:0] opos, olen);
        logic [63:0] lim, q, p, n;
        lim = cpos + clen;
        opos = 0; olen = 0;
        if (lim == 0 || llen == 0) return 0;
        q = spos * clen / llen;
        p = (q >= clen) ? lim - 1 : cpos + q;
        if (p >= lim) p = lim - 1;
        n = slen * clen / llen;
        if (n == 0) n = 1;
        if (n > lim - p) n = lim - p;
        opos = p; olen = n;
        return 1;
    endfunction

    function automatic ifp_pkg::t_rsp place_image(ifp_pkg::t_req r);
        logic [63:0]   iw, ih, tw, th, dw, dh, vw, vh;
        t_box          src, dst, cov;
        bit            ok;
        ifp_pkg::t_rsp o;
        iw = 64'(r.image_w); ih = 64'(r.image_h);
        tw = 64'(r.target_w); th = 64'(r.target_h);
        src = '{0, 0, 0, 0};
        dst = '{0, 0, tw, th};
        ok = 1;
        case (r.req_type)
            ifp_pkg::MODE_COVER: ok = cover_fit(iw, ih, tw, th, src);
            ifp_pkg::MODE_CONTAIN: begin
                src.w = iw; src.h = ih;
                if (iw * th > tw * ih) begin
                    dw = tw;
                    dh = (iw != 0) ? ih * tw / iw : 0;
                    if (iw == 0) ok = 0;
                end else begin
                    dh = th;
                    dw = (ih != 0) ? iw * th / ih : 0;
                    if (ih == 0) ok = 0;
                end
                if (dw == 0) dw = 1;
                if (dh == 0) dh = 1;
                if (dw > tw || dh > th) ok = 0;
                if (ok) dst = '{(tw - dw) / 2, (th - dh) / 2, dw, dh};
            end
            ifp_pkg::MODE_SPAN: begin
                if (r.canvas_w == 0 || r.canvas_h == 0 || r.slice_w == 0 || r.slice_h == 0)
                    ok = cover_fit(iw, ih, tw, th, src);
                else begin
                    ok = cover_fit(iw, ih, 64'(r.canvas_w), 64'(r.canvas_h), cov);
                    if (ok) ok = slice_axis(cov.x, cov.w, 64'(r.slice_x), 64'(r.slice_w),
                                            64'(r.canvas_w), src.x, src.w);
                    if (ok) ok = slice_axis(cov.y, cov.h, 64'(r.slice_y), 64'(r.slice_h),
                                            64'(r.canvas_h), src.y, src.h);
                end
            end
            default: begin
                vw = (iw < tw) ? iw : tw;
                vh = (ih < th) ? ih : th;
                src = '{(iw - vw) / 2, (ih - vh) / 2, vw, vh};
                dst = '{(tw - vw) / 2, (th - vh) / 2, vw, vh};
            end
        endcase
        if (!ok) begin
            o = '0;
            o.bad_size = 1'b1;
        end else begin
            o.crop_x = src.x[15:0]; o.crop_y = src.y[15:0];
            o.crop_w = src.w[15:0]; o.crop_h = src.h[15:0];
            o.place_x = dst.x[15:0]; o.place_y = dst.y[15:0];
            o.place_w = dst.w[15:0]; o.place_h = dst.h[15:0];
            o.bad_size = 1'b0;
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        ifp_pkg::t_rsp want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) placement_queue.push_back(place_image(i_req));
            if (i_out_valid && !i_stall) begin
                if (placement_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_rsp);
                    fail_count++;
                end else begin
                    want = placement_queue.pop_front();
                    if (want !== i_rsp) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, i_rsp);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: test/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the placement unit.
`timescale 1ns / 100ps

module testbench;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    ifp_pkg::t_req i_req = '0;
    logic          o_stall, o_valid;
    ifp_pkg::t_rsp o_rsp;
    int            fail_count, pending;
    int            idle_cycles = 0;
    bit            calm = 0;       // No random idling on either side while set.
    bit            hold_off = 0;   // Receiver holds off for a long stretch while set.

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 53;

    image_fit_placement_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    placement_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_req(i_req), .i_out_valid(o_valid), .i_stall(i_stall), .i_rsp(o_rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Returns a dimension that favors the edges: zero, one, the top, any value, or small values.
    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    // Sends one transaction: it changes on the falling edge and stays until accepted.
    task automatic send_request(ifp_pkg::t_req r);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The receiver stalls at random, except during the calm stretch or a hold-off.
    initial begin
        int count;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                for (count = 0; count < 300; count++) @(negedge i_clk);
                hold_off = 0;
                i_stall <= 1'b0;
            end else
                i_stall <= !calm && ($urandom_range(0, 99) < 6);
        end
    end

    // The watchdog counts cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        ifp_pkg::t_req r;
        int n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: every mode with zero, full-scale and mixed sizes.
        for (n = 0; n < 24; n++) begin
            r = '0;
            r.req_type = n[1:0];
            case (n / 4)
                0: ;
                1: r = '{n[1:0], 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: r = '{n[1:0], 16'd1920, 16'd1080, 16'd0, 16'd600, 16'd3840,
                         16'd1080, 16'd1920, 16'd0, 16'd1920, 16'd1080};
                3: r = '{n[1:0], 16'd1000, 16'd0, 16'd800, 16'd600, 16'd3000,
                         16'd1000, 16'd5000, 16'd2000, 16'd10, 16'd1};
                4: r = '{n[1:0], 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd2,
                         16'd1, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
                default: r = '{n[1:0], 16'd640, 16'd480, 16'd800, 16'd600, 16'd0,
                               16'd600, 16'd0, 16'd0, 16'd0, 16'd0};
            endcase
            send_request(r);
        end

        // Random requests; a calm stretch in the middle and one long hold-off.
        for (n = 0; n < 1550; n++) begin
            calm = (n >= 400 && n < 700);
            if (n == 900) hold_off = 1;
            r.req_type = 2'($urandom);
            r.image_w = pick_dim(); r.image_h = pick_dim();
            r.target_w = pick_dim(); r.target_h = pick_dim();
            r.canvas_w = pick_dim(); r.canvas_h = pick_dim();
            r.slice_x = pick_dim(); r.slice_y = pick_dim();
            r.slice_w = pick_dim(); r.slice_h = pick_dim();
            send_request(r);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/ifp_pkg.sv
rtl/ifp_div_cell.sv
rtl/ifp_div_chain.sv
rtl/image_fit_placement_unit.sv
rtl/ifp_checker.sv
test/placement_checker.sv
test/testbench.sv
